### sv/dhf_pkg.sv
// Shared constants for the depth hole fill block.
package dhf_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;
    localparam int DEF_MAX_RADIUS = 7;
    localparam int DEF_DEPTH_BITS = 16;

    localparam int CFG_DATA_W = 11;
    localparam int CFG_IDX_W  = 3;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FILL_ENABLE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FILL_RADIUS  = 3'd3;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    localparam logic [10:0] RST_FRAME_WIDTH  = 11'd640;
    localparam logic [10:0] RST_FRAME_HEIGHT = 11'd480;
    localparam logic        RST_FILL_ENABLE  = 1'b1;
    localparam logic [2:0]  RST_FILL_RADIUS  = 3'd2;

endpackage

### sv/dhf_store.sv
// Line store: single-port-write, single-port-read synchronous memory.
module dhf_store
    import dhf_pkg::*;
#(
    parameter int DEPTH      = 15360,
    parameter int ADDR_W     = 14,
    parameter int DATA_W     = 16
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### sv/depth_hole_fill_nearest.sv
// Top level: nearest-neighbor depth hole filling over a raster pixel stream.
// Each pixel word of a frame accepted on s_ is stored in a line store of
// (2*MAX_RADIUS+1)*MAX_WIDTH entries; a pixel is emitted on m_ once R*W+R later pixels
// have arrived (or the frame is complete, with drain words flushing the tail). A nonzero
// pixel is passed on as it is; a hole scans its clipped window through the
// single read port of the line store, one entry per cycle. No clearing pass is needed
// after reset.
module depth_hole_fill_nearest
    import dhf_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int MAX_RADIUS = DEF_MAX_RADIUS,
    parameter int DEPTH_BITS = DEF_DEPTH_BITS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_cmd,
    input  logic [DEPTH_BITS-1:0] s_depth_in,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [DEPTH_BITS-1:0] m_depth_out,
    output logic                  m_was_filled,
    output logic                  m_frame_last
);

    localparam int STORE_DEPTH = (2 * MAX_RADIUS + 1) * MAX_WIDTH;
    localparam int AW   = $clog2(STORE_DEPTH);
    localparam int WW   = $clog2(MAX_WIDTH + 1);
    localparam int HW   = $clog2(MAX_HEIGHT + 1);
    localparam int CNTW = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
    localparam int RW   = $clog2(MAX_RADIUS + 1);
    localparam int WINW = $clog2(2 * MAX_RADIUS + 1);
    localparam int D2W  = $clog2(2 * MAX_RADIUS * MAX_RADIUS + 2);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_OWN    = 7'b0000010,
        S_OWNCHK = 7'b0000100,
        S_BACK   = 7'b0001000,
        S_SCAN   = 7'b0010000,
        S_FLUSH  = 7'b0100000,
        S_DONE   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [10:0] cfg_w_reg, cfg_h_reg;
    logic        cfg_en_reg;
    logic [2:0]  cfg_r_reg;

    logic [CNTW-1:0] acc_reg, acc_next, emit_reg, emit_next;
    logic [AW-1:0]   wr_addr_reg, wr_addr_next;
    logic [HW-1:0]   e_row_reg, e_row_next;
    logic [WW-1:0]   e_col_reg, e_col_next;
    logic [AW-1:0]   e_addr_reg, e_addr_next;

    logic [RW-1:0]   up_reg, up_next, down_reg, down_next;
    logic [RW-1:0]   left_reg, left_next, right_reg, right_next;
    logic [RW-1:0]   cnt_reg, cnt_next;
    logic [AW-1:0]   row_addr_reg, row_addr_next, cur_reg, cur_next;
    logic [WINW-1:0] ri_reg, ri_next, ci_reg, ci_next;
    logic            p_valid_reg;
    logic [D2W-1:0]  p_d2_reg;
    logic [D2W-1:0]  best_d_reg, best_d_next;
    logic [DEPTH_BITS-1:0] best_reg, best_next;
    logic            search_reg, search_next;
    logic            last_reg, last_next;

    logic                  m_valid_reg;
    logic [DEPTH_BITS-1:0] m_depth_reg;
    logic                  m_fill_reg, m_last_reg;

    // effective configuration
    logic [WW-1:0]   eff_w;
    logic [HW-1:0]   eff_h;
    logic [RW-1:0]   eff_r;
    logic [CNTW-1:0] total, lag;

    always_comb begin
        if (cfg_w_reg == 11'd0) begin
            eff_w = WW'(1);
        end else if (32'(cfg_w_reg) > MAX_WIDTH) begin
            eff_w = WW'(MAX_WIDTH);
        end else begin
            eff_w = WW'(cfg_w_reg);
        end
        if (cfg_h_reg == 11'd0) begin
            eff_h = HW'(1);
        end else if (32'(cfg_h_reg) > MAX_HEIGHT) begin
            eff_h = HW'(MAX_HEIGHT);
        end else begin
            eff_h = HW'(cfg_h_reg);
        end
        if (!cfg_en_reg) begin
            eff_r = '0;
        end else if (32'(cfg_r_reg) > MAX_RADIUS) begin
            eff_r = RW'(MAX_RADIUS);
        end else begin
            eff_r = RW'(cfg_r_reg);
        end
    end

    assign total = CNTW'(CNTW'(eff_w) * CNTW'(eff_h));
    assign lag   = CNTW'(CNTW'(eff_r) * CNTW'(eff_w) + CNTW'(eff_r));

    // store access
    logic                  st_we, st_re;
    logic [AW-1:0]         st_raddr;
    logic [DEPTH_BITS-1:0] st_rdata;

    dhf_store #(
        .DEPTH  (STORE_DEPTH),
        .ADDR_W (AW),
        .DATA_W (DEPTH_BITS)
    ) u_store (
        .aclk  (aclk),
        .we    (st_we),
        .waddr (wr_addr_reg),
        .wdata (s_depth_in),
        .re    (st_re),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    logic in_acc, do_write, emit_now, cfg_hit, out_free;
    logic [CNTW-1:0] acc_new;

    assign s_ready  = (state_reg == S_IDLE);
    assign in_acc   = s_valid && s_ready;
    assign do_write = in_acc && (s_cmd == CMD_PIXEL) && (acc_reg < total);
    assign acc_new  = do_write ? acc_reg + CNTW'(1) : acc_reg;
    assign emit_now = in_acc && (emit_reg < acc_new)
                      && ((acc_new == total) || ((acc_new - emit_reg) > lag));
    assign cfg_hit  = cfg_we && (cfg_index == REG_FRAME_WIDTH
                      || cfg_index == REG_FRAME_HEIGHT || cfg_index == REG_FILL_ENABLE
                      || cfg_index == REG_FILL_RADIUS);
    assign out_free = !m_valid_reg || m_ready;
    assign st_we    = do_write;

    function automatic logic [AW-1:0] inc_mod(input logic [AW-1:0] a,
                                              input logic [WW-1:0] b);
        logic [AW:0] s;
        s = (AW+1)'(a) + (AW+1)'(b);
        if (s >= (AW+1)'(STORE_DEPTH)) begin
            s = s - (AW+1)'(STORE_DEPTH);
        end
        return s[AW-1:0];
    endfunction

    function automatic logic [AW-1:0] dec_mod(input logic [AW-1:0] a,
                                              input logic [WW-1:0] b);
        logic [AW:0] s;
        if ((AW+1)'(a) >= (AW+1)'(b)) begin
            s = (AW+1)'(a) - (AW+1)'(b);
        end else begin
            s = (AW+1)'(a) + (AW+1)'(STORE_DEPTH) - (AW+1)'(b);
        end
        return s[AW-1:0];
    endfunction

    // window distance of the position being issued
    logic [WINW-1:0] dr, dc;
    logic [D2W-1:0]  d2;
    logic            scan_end;

    always_comb begin
        dr = (ri_reg > WINW'(up_reg)) ? ri_reg - WINW'(up_reg) : WINW'(up_reg) - ri_reg;
        dc = (ci_reg > WINW'(left_reg)) ? ci_reg - WINW'(left_reg)
                                         : WINW'(left_reg) - ci_reg;
        d2 = D2W'(D2W'(dr) * D2W'(dr) + D2W'(dc) * D2W'(dc));
        scan_end = (ri_reg == WINW'(WINW'(up_reg) + WINW'(down_reg)))
                   && (ci_reg == WINW'(WINW'(left_reg) + WINW'(right_reg)));
    end

    logic [HW-1:0] rows_below;
    logic [WW-1:0] cols_right;
    assign rows_below = eff_h - HW'(1) - e_row_reg;
    assign cols_right = eff_w - WW'(1) - e_col_reg;

    always_comb begin
        state_next    = state_reg;
        acc_next      = acc_reg;
        emit_next     = emit_reg;
        wr_addr_next  = wr_addr_reg;
        e_row_next    = e_row_reg;
        e_col_next    = e_col_reg;
        e_addr_next   = e_addr_reg;
        up_next       = up_reg;
        down_next     = down_reg;
        left_next     = left_reg;
        right_next    = right_reg;
        cnt_next      = cnt_reg;
        row_addr_next = row_addr_reg;
        cur_next      = cur_reg;
        ri_next       = ri_reg;
        ci_next       = ci_reg;
        best_d_next   = best_d_reg;
        best_next     = best_reg;
        search_next   = search_reg;
        last_next     = last_reg;
        st_re         = 1'b0;
        st_raddr      = e_addr_reg;

        // compare stage acts on the read issued in the previous cycle
        if (p_valid_reg && st_rdata != '0 && p_d2_reg < best_d_reg) begin
            best_d_next = p_d2_reg;
            best_next   = st_rdata;
        end

        case (state_reg)
            S_IDLE: begin
                if (do_write) begin
                    acc_next     = acc_new;
                    wr_addr_next = inc_mod(wr_addr_reg, WW'(1));
                end
                if (emit_now) begin
                    state_next = S_OWN;
                end
            end
            S_OWN: begin
                st_re      = 1'b1;
                st_raddr   = e_addr_reg;
                last_next  = (emit_reg + CNTW'(1)) == total;
                state_next = S_OWNCHK;
            end
            S_OWNCHK: begin
                if (st_rdata != '0 || eff_r == '0) begin
                    best_next   = st_rdata;
                    search_next = 1'b0;
                    state_next  = S_DONE;
                end else begin
                    up_next     = (e_row_reg > HW'(eff_r)) ? eff_r : RW'(e_row_reg);
                    down_next   = (rows_below > HW'(eff_r)) ? eff_r : RW'(rows_below);
                    left_next   = (e_col_reg > WW'(eff_r)) ? eff_r : RW'(e_col_reg);
                    right_next  = (cols_right > WW'(eff_r)) ? eff_r : RW'(cols_right);
                    cnt_next    = up_next;
                    cur_next    = dec_mod(e_addr_reg, WW'(left_next));
                    best_next   = '0;
                    best_d_next = D2W'(D2W'(eff_r) * D2W'(eff_r) + D2W'(1));
                    search_next = 1'b1;
                    state_next  = S_BACK;
                end
            end
            S_BACK: begin
                // step back one row per cycle to the window's top-left entry
                if (cnt_reg == '0) begin
                    row_addr_next = cur_reg;
                    ri_next       = '0;
                    ci_next       = '0;
                    state_next    = S_SCAN;
                end else begin
                    cur_next = dec_mod(cur_reg, eff_w);
                    cnt_next = cnt_reg - RW'(1);
                end
            end
            S_SCAN: begin
                st_re    = 1'b1;
                st_raddr = cur_reg;
                if (scan_end) begin
                    state_next = S_FLUSH;
                end else if (ci_reg == WINW'(WINW'(left_reg) + WINW'(right_reg))) begin
                    ci_next       = '0;
                    ri_next       = ri_reg + WINW'(1);
                    row_addr_next = inc_mod(row_addr_reg, eff_w);
                    cur_next      = row_addr_next;
                end else begin
                    ci_next  = ci_reg + WINW'(1);
                    cur_next = inc_mod(cur_reg, WW'(1));
                end
            end
            S_FLUSH: begin
                state_next = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                    if (last_reg) begin
                        acc_next     = '0;
                        emit_next    = '0;
                        wr_addr_next = '0;
                        e_row_next   = '0;
                        e_col_next   = '0;
                        e_addr_next  = '0;
                    end else begin
                        emit_next   = emit_reg + CNTW'(1);
                        e_addr_next = inc_mod(e_addr_reg, WW'(1));
                        if (e_col_reg == eff_w - WW'(1)) begin
                            e_col_next = '0;
                            e_row_next = e_row_reg + HW'(1);
                        end else begin
                            e_col_next = e_col_reg + WW'(1);
                        end
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // a register write abandons the frame in progress
        if (cfg_hit) begin
            acc_next     = '0;
            emit_next    = '0;
            wr_addr_next = '0;
            e_row_next   = '0;
            e_col_next   = '0;
            e_addr_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cfg_w_reg   <= RST_FRAME_WIDTH;
            cfg_h_reg   <= RST_FRAME_HEIGHT;
            cfg_en_reg  <= RST_FILL_ENABLE;
            cfg_r_reg   <= RST_FILL_RADIUS;
            acc_reg     <= '0;
            emit_reg    <= '0;
            wr_addr_reg <= '0;
            e_row_reg   <= '0;
            e_col_reg   <= '0;
            e_addr_reg  <= '0;
            p_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            acc_reg     <= acc_next;
            emit_reg    <= emit_next;
            wr_addr_reg <= wr_addr_next;
            e_row_reg   <= e_row_next;
            e_col_reg   <= e_col_next;
            e_addr_reg  <= e_addr_next;
            p_valid_reg <= (state_reg == S_SCAN);
            if (cfg_we) begin
                case (cfg_index)
                    REG_FRAME_WIDTH:  cfg_w_reg  <= cfg_wdata;
                    REG_FRAME_HEIGHT: cfg_h_reg  <= cfg_wdata;
                    REG_FILL_ENABLE:  cfg_en_reg <= cfg_wdata[0];
                    REG_FILL_RADIUS:  cfg_r_reg  <= cfg_wdata[2:0];
                    default: ;
                endcase
            end
            if (state_reg == S_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        up_reg       <= up_next;
        down_reg     <= down_next;
        left_reg     <= left_next;
        right_reg    <= right_next;
        cnt_reg      <= cnt_next;
        row_addr_reg <= row_addr_next;
        cur_reg      <= cur_next;
        ri_reg       <= ri_next;
        ci_reg       <= ci_next;
        best_d_reg   <= best_d_next;
        best_reg     <= best_next;
        search_reg   <= search_next;
        last_reg     <= last_next;
        p_d2_reg     <= d2;
        if (state_reg == S_DONE && out_free) begin
            m_depth_reg <= best_reg;
            m_fill_reg  <= search_reg && (best_reg != '0);
            m_last_reg  <= last_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_depth_out  = m_depth_reg;
    assign m_was_filled = m_fill_reg;
    assign m_frame_last = m_last_reg;

    // the store is written only between searches
    a_write_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        st_we |-> state_reg == S_IDLE)
        else $error("line store written during a search");

    // never emit more pixels than were accepted
    a_count_order: assert property (@(posedge aclk) disable iff (!aresetn)
        emit_reg <= acc_reg)
        else $error("emit count ahead of accept count");

    // a pending compare only follows a scan issue
    a_compare_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        p_valid_reg |-> $past(state_reg) == S_SCAN)
        else $error("compare without a scan read");

endmodule

### sim/tb_depth_hole_fill_nearest.sv
// Self-checking testbench for the nearest-neighbor depth hole fill block.
module tb_depth_hole_fill_nearest;
    import dhf_pkg::*;

    localparam int STORE_WORDS = (2 * DEF_MAX_RADIUS + 1) * DEF_MAX_WIDTH;
    localparam int SETTLE_CYCLES = 4 + DEF_MAX_RADIUS + (2 * DEF_MAX_RADIUS + 1) ** 2 + 50;
    localparam int RANDOM_PIXELS = 550;

    typedef struct packed {
        logic [15:0] depth;
        logic        filled;
        logic        last;
    } pix_out_t;

    typedef enum logic [1:0] {ROW_CFG, ROW_WORD, ROW_WORD_EXP} row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        logic [2:0]  index;
        logic        cmd;
        logic [15:0] value;
        pix_out_t    res;
    } row_t;

    localparam int N_ROWS = 30;
    localparam row_t DIRECTED [0:N_ROWS-1] = '{
        // pass-through frame, 4x2, filling off
        '{ROW_CFG, REG_FRAME_WIDTH, CMD_PIXEL, 16'd4, '0},
        '{ROW_CFG, REG_FRAME_HEIGHT, CMD_PIXEL, 16'd2, '0},
        '{ROW_CFG, REG_FILL_ENABLE, CMD_PIXEL, 16'd0, '0},
        '{ROW_CFG, REG_FILL_RADIUS, CMD_PIXEL, 16'd7, '0},
        '{ROW_WORD_EXP, 3'd0, CMD_PIXEL, 16'hFFFF, '{16'hFFFF, 1'b0, 1'b0}},
        '{ROW_WORD_EXP, 3'd0, CMD_PIXEL, 16'h0000, '{16'h0000, 1'b0, 1'b0}},
        '{ROW_WORD_EXP, 3'd0, CMD_PIXEL, 16'h0001, '{16'h0001, 1'b0, 1'b0}},
        '{ROW_WORD_EXP, 3'd0, CMD_PIXEL, 16'h8000, '{16'h8000, 1'b0, 1'b0}},
        '{ROW_WORD_EXP, 3'd0, CMD_PIXEL, 16'h7FFF, '{16'h7FFF, 1'b0, 1'b0}},
        '{ROW_WORD_EXP, 3'd0, CMD_PIXEL, 16'h0000, '{16'h0000, 1'b0, 1'b0}},
        '{ROW_WORD_EXP, 3'd0, CMD_PIXEL, 16'h0002, '{16'h0002, 1'b0, 1'b0}},
        '{ROW_WORD_EXP, 3'd0, CMD_PIXEL, 16'hFFFF, '{16'hFFFF, 1'b0, 1'b1}},
        // drain at the start of a frame: nothing to emit
        '{ROW_WORD, 3'd0, CMD_DRAIN, 16'hFFFF, '0},
        // 3x3 frame, radius 1, mostly holes
        '{ROW_CFG, REG_FILL_ENABLE, CMD_PIXEL, 16'd1, '0},
        '{ROW_CFG, REG_FILL_RADIUS, CMD_PIXEL, 16'd1, '0},
        '{ROW_CFG, REG_FRAME_WIDTH, CMD_PIXEL, 16'd3, '0},
        '{ROW_CFG, REG_FRAME_HEIGHT, CMD_PIXEL, 16'd3, '0},
        '{ROW_WORD, 3'd0, CMD_PIXEL, 16'h0000, '0},
        '{ROW_WORD, 3'd0, CMD_PIXEL, 16'd5, '0},
        '{ROW_WORD, 3'd0, CMD_DRAIN, 16'h0000, '0},
        '{ROW_WORD, 3'd0, CMD_PIXEL, 16'h0000, '0},
        '{ROW_WORD, 3'd0, CMD_PIXEL, 16'h0000, '0},
        '{ROW_WORD, 3'd0, CMD_PIXEL, 16'h0000, '0},
        '{ROW_WORD, 3'd0, CMD_PIXEL, 16'h0000, '0},
        '{ROW_WORD, 3'd0, CMD_PIXEL, 16'd9, '0},
        '{ROW_WORD, 3'd0, CMD_PIXEL, 16'h0000, '0},
        '{ROW_WORD, 3'd0, CMD_PIXEL, 16'h0000, '0},
        // frame complete: a pixel is dropped and acts as a drain
        '{ROW_WORD, 3'd0, CMD_PIXEL, 16'd1234, '0},
        '{ROW_WORD, 3'd0, CMD_DRAIN, 16'h0000, '0},
        '{ROW_WORD, 3'd0, CMD_DRAIN, 16'h0000, '0}
    };

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_valid;
    logic                  s_ready;
    logic                  s_cmd;
    logic [15:0]           s_depth_in;
    logic                  m_valid;
    logic                  m_ready;
    logic [15:0]           m_depth_out;
    logic                  m_was_filled;
    logic                  m_frame_last;

    depth_hole_fill_nearest dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_cmd       (s_cmd),
        .s_depth_in  (s_depth_in),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_depth_out (m_depth_out),
        .m_was_filled(m_was_filled),
        .m_frame_last(m_frame_last)
    );

    // shadow of the block state
    logic [15:0] depth_store [0:STORE_WORDS-1];
    int unsigned n_accepted;
    int unsigned n_emitted;
    logic [10:0] width_reg;
    logic [10:0] height_reg;
    logic        enable_reg;
    logic [2:0]  radius_reg;

    pix_out_t pending_pixels [$];
    int       error_count;
    logic     calm;
    int       pixels_sent;

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #10000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic int unsigned eff_w();
        int unsigned w;
        w = width_reg;
        if (w == 0) w = 1;
        if (w > DEF_MAX_WIDTH) w = DEF_MAX_WIDTH;
        return w;
    endfunction

    function automatic int unsigned eff_h();
        int unsigned h;
        h = height_reg;
        if (h == 0) h = 1;
        if (h > DEF_MAX_HEIGHT) h = DEF_MAX_HEIGHT;
        return h;
    endfunction

    function automatic int unsigned eff_r();
        return enable_reg ? int'(radius_reg) : 0;
    endfunction

    function automatic logic [15:0] stored_at(int unsigned row, int unsigned col, int unsigned w);
        return depth_store[(row * w + col) % STORE_WORDS];
    endfunction

    function automatic pix_out_t nearest_fill(int unsigned idx, int unsigned w, int unsigned h,
                                              int unsigned rad);
        pix_out_t    p;
        int unsigned row, col, best_d, r0, r1, c0, c1, dr, dc, d2;
        logic [15:0] own, best, v;
        row = idx / w;
        col = idx % w;
        own = stored_at(row, col, w);
        p = '0;
        if (own != 0 || rad == 0) begin
            p.depth = own;
            return p;
        end
        best = '0;
        best_d = rad * rad + 1;
        r0 = row > rad ? row - rad : 0;
        r1 = row + rad < h - 1 ? row + rad : h - 1;
        c0 = col > rad ? col - rad : 0;
        c1 = col + rad < w - 1 ? col + rad : w - 1;
        for (int unsigned rr = r0; rr <= r1; rr++) begin
            for (int unsigned cc = c0; cc <= c1; cc++) begin
                v = stored_at(rr, cc, w);
                dr = rr > row ? rr - row : row - rr;
                dc = cc > col ? cc - col : col - cc;
                d2 = dr * dr + dc * dc;
                // strict compare keeps the first pixel in scan order on a tie
                if (v != 0 && d2 < best_d) begin
                    best_d = d2;
                    best = v;
                end
            end
        end
        p.depth = best;
        p.filled = best != 0;
        return p;
    endfunction

    // advance the shadow by one accepted word; returns 1 with a pixel when one is emitted
    function automatic bit advance_fill(logic cmd, logic [15:0] d, output pix_out_t p);
        int unsigned w, h, rad, total, lag;
        w = eff_w();
        h = eff_h();
        rad = eff_r();
        total = w * h;
        lag = rad * w + rad;
        p = '0;
        if (cmd == CMD_PIXEL && n_accepted < total) begin
            depth_store[n_accepted % STORE_WORDS] = d;
            n_accepted++;
        end
        if (n_emitted >= n_accepted) return 0;
        if (n_accepted != total && n_accepted - n_emitted <= lag) return 0;
        p = nearest_fill(n_emitted, w, h, rad);
        n_emitted++;
        p.last = n_emitted == total;
        if (p.last) begin
            n_accepted = 0;
            n_emitted = 0;
        end
        return 1;
    endfunction

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [10:0] val);
        wait_idle();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            REG_FRAME_WIDTH:  width_reg = val;
            REG_FRAME_HEIGHT: height_reg = val;
            REG_FILL_ENABLE:  enable_reg = val[0];
            REG_FILL_RADIUS:  radius_reg = val[2:0];
            default: ;
        endcase
        n_accepted = 0;
        n_emitted = 0;
    endtask

    // present one word and hold it until accepted; typed expectation overrides the shadow
    task automatic send_word(logic cmd, logic [15:0] d, bit typed, pix_out_t typed_res);
        pix_out_t p;
        bit       hit;
        if (!calm && $urandom_range(99) < 25) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_cmd <= cmd;
        s_depth_in <= d;
        do @(posedge aclk); while (!s_ready);
        hit = advance_fill(cmd, d, p);
        if (typed) pending_pixels.push_back(typed_res);
        else if (hit) pending_pixels.push_back(p);
    endtask

    function automatic logic [15:0] rand_depth();
        int unsigned k;
        k = $urandom_range(99);
        if (k < 40) return 16'h0000;
        if (k < 45) return 16'hFFFF;
        return 16'($urandom_range(65535, 1));
    endfunction

    // one frame of random content, with noise drains, an optional abandon and a drain tail
    task automatic run_frame(bit allow_abandon);
        int unsigned total, stop_at, k;
        total = eff_w() * eff_h();
        stop_at = (allow_abandon && $urandom_range(9) == 0) ? $urandom_range(total) : total;
        for (int unsigned i = 0; i < stop_at; i++) begin
            if ($urandom_range(99) < 6) send_word(CMD_DRAIN, 16'($urandom), 0, '0);
            send_word(CMD_PIXEL, rand_depth(), 0, '0);
            pixels_sent++;
        end
        if (stop_at != total) return;
        while (n_accepted != 0) begin
            k = $urandom_range(99);
            if (k < 20) send_word(CMD_PIXEL, 16'($urandom), 0, '0);
            else send_word(CMD_DRAIN, 16'($urandom), 0, '0);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) m_ready <= 1'b0;
        else m_ready <= calm || ($urandom_range(99) >= 25);
    end

    always @(posedge aclk) begin
        pix_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_pixels.size() == 0) begin
                $error("unexpected word: depth_out %0h", m_depth_out);
                error_count++;
            end else begin
                want = pending_pixels.pop_front();
                if (m_depth_out !== want.depth) begin
                    $error("depth_out: expected %0h, got %0h", want.depth, m_depth_out);
                    error_count++;
                end
                if (m_was_filled !== want.filled) begin
                    $error("was_filled: expected %0b, got %0b", want.filled, m_was_filled);
                    error_count++;
                end
                if (m_frame_last !== want.last) begin
                    $error("frame_last: expected %0b, got %0b", want.last, m_frame_last);
                    error_count++;
                end
            end
        end
    end

    initial begin
        int unsigned phase;
        error_count = 0;
        calm = 1'b0;
        pixels_sent = 0;
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_valid = 1'b0;
        s_cmd = CMD_PIXEL;
        s_depth_in = '0;
        n_accepted = 0;
        n_emitted = 0;
        width_reg = RST_FRAME_WIDTH;
        height_reg = RST_FRAME_HEIGHT;
        enable_reg = RST_FILL_ENABLE;
        radius_reg = RST_FILL_RADIUS;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (DIRECTED[i]) begin
            if (DIRECTED[i].kind == ROW_CFG)
                write_reg(DIRECTED[i].index, DIRECTED[i].value[10:0]);
            else
                send_word(DIRECTED[i].cmd, DIRECTED[i].value,
                          DIRECTED[i].kind == ROW_WORD_EXP, DIRECTED[i].res);
        end

        pixels_sent = 0;
        phase = 0;
        while (pixels_sent < RANDOM_PIXELS) begin
            calm = (phase % 9) == 4;
            case ($urandom_range(9))
                0: write_reg(REG_FRAME_WIDTH, 11'd0);
                1: write_reg(REG_FRAME_WIDTH, 11'($urandom_range(24, 9)));
                default: write_reg(REG_FRAME_WIDTH, 11'($urandom_range(8, 1)));
            endcase
            if ($urandom_range(9) == 0) write_reg(REG_FRAME_HEIGHT, 11'd0);
            else write_reg(REG_FRAME_HEIGHT, 11'($urandom_range(8, 1)));
            write_reg(REG_FILL_ENABLE, 11'($urandom_range(9) != 0));
            write_reg(REG_FILL_RADIUS, 11'($urandom_range(7)));
            if (phase == 3) begin
                // hold the sender mid-frame until the block has caught up
                send_word(CMD_PIXEL, rand_depth(), 0, '0);
                s_valid <= 1'b0;
                while (pending_pixels.size() != 0) @(posedge aclk);
            end
            run_frame(1);
            phase++;
        end
        calm = 1'b0;

        wait_idle();
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
